[hw/rtl/htd_pkg.sv]
// Shared types, constants and table function for the dew-point converter.
`timescale 1ns / 1ps

package htd_pkg;

    // Default depth of the log2 interpolation table
    localparam int LOG_DEPTH_DEFAULT = 256;

    // Q28 fraction width of the log values
    localparam int QBITS = 28;

    // Reciprocals for the constant dividers: ceil(2^k / d)
    localparam longint unsigned HUM_RECIP = ((64'd1 << 47) + 64'd99999) / 64'd100000;
    localparam longint unsigned Q0_RECIP  = ((64'd1 << 47) + 64'd78124) / 64'd78125;
    localparam longint unsigned Q1_RECIP  = ((64'd1 << 43) + 64'd78124) / 64'd78125;

    // log10(2) in Q30
    localparam longint unsigned LOG10_2_Q30 = 64'd323228497;

    // Measurement data leaving the humidity / log path
    typedef struct packed {
        logic signed [14:0] tc;
        logic [13:0]        hum;
        logic signed [31:0] l10;
    } meas_t;

    // Data carried beside the dew-point divider
    typedef struct packed {
        logic signed [14:0] tc;
        logic [13:0]        hum;
        logic               lneg;
        logic               bad;
    } dside_t;

    // Fractional log2 of x (Q28, 1 <= x < 2) by repeated squaring
    function automatic logic [28:0] frac_log2(input logic [63:0] x_in);
        logic [63:0] x;
        logic [28:0] y;
        x = x_in;
        y = '0;
        for (int b = QBITS - 1; b >= 0; b--) begin
            x = (x * x) >> QBITS;
            if (x >= (64'd2 << QBITS)) begin
                x = x >> 1;
                y[b] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage

[hw/rtl/htd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
`timescale 1ns / 1ps

module htd_div #(
    parameter int QW = 30,
    parameter int DW = 19,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] num_hi,
    input  logic [QW-1:0] num_lo,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [QW-1:0] v_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] lo_next  [QW];
    logic [QW-1:0] q_next   [QW];
    logic [DW-1:0] den_next [QW];

    // One compare-subtract per stage
    always_comb begin
        logic [DW-1:0] r;
        logic [QW-1:0] l;
        logic [QW-1:0] q;
        logic [DW-1:0] d;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                r = num_hi;
                l = num_lo;
                q = '0;
                d = den;
            end else begin
                r = rem_reg[k-1];
                l = lo_reg[k-1];
                q = q_reg[k-1];
                d = den_reg[k-1];
            end
            trial = {r, l[QW-1]};
            diff  = trial - {1'b0, d};
            rem_next[k] = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            lo_next[k]  = l << 1;
            q_next[k]   = {q[QW-2:0], ~diff[DW]};
            den_next[k] = d;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < QW; k++) begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= den_next[k];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < QW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

[hw/rtl/htd_rhlog.sv]
// Humidity compensation, clamp, Q16 scaling and table-interpolated log10 pipeline.
`timescale 1ns / 1ps

module htd_rhlog #(
    parameter int LOG_TABLE_DEPTH = htd_pkg::LOG_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [11:0]   raw_humidity,
    input  logic [13:0]   raw_temperature,
    output logic          out_valid,
    output htd_pkg::meas_t out_meas
);

    localparam int NS  = 17;
    localparam int IW  = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int FDW = 22 + IW;

    // Leading-one position of the Q16 humidity
    function automatic logic [4:0] lead_one(input logic [22:0] v);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < 23; b++) begin
            if (v[b]) begin
                p = 5'(b);
            end
        end
        return p;
    endfunction

    // log2(1 + i/depth) table in Q28, built at elaboration
    logic [28:0] rom [0:LOG_TABLE_DEPTH];
    for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_rom
        if (g == LOG_TABLE_DEPTH) begin : g_top
            assign rom[g] = 29'd1 << htd_pkg::QBITS;
        end else begin : g_ent
            localparam logic [63:0] X = (64'd1 << 28) + ((64'(g) << 28) / LOG_TABLE_DEPTH);
            assign rom[g] = htd_pkg::frac_log2(X);
        end
    end

    logic [NS:1]        v_reg;
    logic signed [14:0] tc_reg  [1:NS];
    logic [13:0]        hum_reg [4:NS];

    logic [11:0]        rh1_reg;
    logic [23:0]        sq1_reg;
    logic signed [27:0] cross1_reg;
    logic signed [33:0] n2_reg;
    logic [29:0]        nc3_reg;
    logic [29:0]        nc4_reg;
    logic [13:0]        q0_4_reg;
    logic [13:0]        q0_5_reg;
    logic [16:0]        r0_5_reg;
    logic [13:0]        q0_6_reg;
    logic [9:0]         q2_6_reg;
    logic [22:0]        hq7_reg;
    logic [22:0]        hq8_reg;
    logic [4:0]         p8_reg;
    logic [21:0]        f9_reg;
    logic [4:0]         p9_reg;
    logic [IW-1:0]      i10_reg;
    logic [21:0]        r10_reg;
    logic [4:0]         p10_reg;
    logic [28:0]        t0_11_reg;
    logic [28:0]        t1_11_reg;
    logic [21:0]        r11_reg;
    logic [4:0]         p11_reg;
    logic [28:0]        step12_reg;
    logic [28:0]        t0_12_reg;
    logic [21:0]        r12_reg;
    logic [4:0]         p12_reg;
    logic [28:0]        sp13_reg;
    logic [28:0]        t0_13_reg;
    logic [4:0]         p13_reg;
    logic signed [33:0] lg14_reg;
    logic [30:0]        mag15_reg;
    logic               neg15_reg;
    logic [59:0]        pr16_reg;
    logic               neg16_reg;
    logic signed [31:0] l10_17_reg;

    logic signed [14:0] rtm;
    logic signed [13:0] rhp;
    logic signed [27:0] cross_next;
    logic [23:0]        sq_next;
    logic signed [14:0] tc_next;
    logic signed [33:0] n_next;
    logic [29:0]        nc_next;
    logic [60:0]        hum_prod;
    logic [60:0]        q0_prod;
    logic [16:0]        r0_next;
    logic [25:0]        y_val;
    logic [52:0]        q2_prod;
    logic [22:0]        hq_next;
    logic [4:0]         p_next;
    logic [22:0]        frac;
    logic [21:0]        f_next;
    logic [FDW-1:0]     fd;
    logic [50:0]        sp_prod;
    logic signed [5:0]  pexp;
    logic signed [33:0] lg_next;
    logic [30:0]        mag_next;
    logic [59:0]        pr_next;
    logic [59:0]        rsum;
    logic signed [31:0] l10_next;

    // Per-stage arithmetic
    always_comb begin
        rtm        = $signed({1'b0, raw_temperature}) - 15'sd6500;
        rhp        = $signed({2'b00, raw_humidity}) + 14'sd125;
        cross_next = rtm * rhp;
        sq_next    = 24'(raw_humidity) * 24'(raw_humidity);
        tc_next    = $signed({1'b0, raw_temperature}) - 15'sd4000;

        n_next = $signed(34'(rh1_reg)) * 34'sd405000 - $signed(34'(sq1_reg)) * 34'sd28
               + (34'(cross1_reg) <<< 3) - 34'sd40000000;

        // Clamp to 0.1 .. 100 %RH
        if (n2_reg < 34'sd1000000) begin
            nc_next = 30'd1000000;
        end else if (n2_reg > 34'sd1000000000) begin
            nc_next = 30'd1000000000;
        end else begin
            nc_next = n2_reg[29:0];
        end

        hum_prod = 61'(nc3_reg + 30'd50000) * 61'(htd_pkg::HUM_RECIP);
        q0_prod  = 61'(nc3_reg) * 61'(htd_pkg::Q0_RECIP);

        r0_next = 17'(nc4_reg - 30'(q0_4_reg) * 30'd78125);

        y_val   = {r0_5_reg, 9'd0} + 26'd39062;
        q2_prod = 53'(y_val) * 53'(htd_pkg::Q1_RECIP);

        hq_next = {q0_6_reg, 9'd0} + 23'(q2_6_reg);
        p_next  = lead_one(hq7_reg);

        // Drop the leading one, left-align to Q22
        frac   = hq8_reg ^ (23'd1 << p8_reg);
        f_next = 22'(frac << (5'd22 - p8_reg));

        fd = FDW'(f9_reg) * FDW'(LOG_TABLE_DEPTH);

        sp_prod = 51'(step12_reg) * 51'(r12_reg);

        pexp    = $signed({1'b0, p13_reg}) - 6'sd16;
        lg_next = (34'(pexp) <<< htd_pkg::QBITS) + 34'(t0_13_reg) + 34'(sp13_reg);

        mag_next = lg14_reg[33] ? 31'(-lg14_reg) : lg14_reg[30:0];
        pr_next  = 60'(mag15_reg) * 60'(htd_pkg::LOG10_2_Q30);

        // Round half away from zero, scale by 2^-30
        rsum     = pr16_reg + 60'd536870912;
        l10_next = neg16_reg ? -$signed({2'b00, rsum[59:30]}) : $signed({2'b00, rsum[59:30]});
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-1:1], in_valid};
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (adv) begin
            tc_reg[1] <= tc_next;
            for (int k = 2; k <= NS; k++) begin
                tc_reg[k] <= tc_reg[k-1];
            end
            hum_reg[4] <= hum_prod[60:47];
            for (int k = 5; k <= NS; k++) begin
                hum_reg[k] <= hum_reg[k-1];
            end

            rh1_reg    <= raw_humidity;
            sq1_reg    <= sq_next;
            cross1_reg <= cross_next;
            n2_reg     <= n_next;
            nc3_reg    <= nc_next;
            nc4_reg    <= nc3_reg;
            q0_4_reg   <= q0_prod[60:47];
            q0_5_reg   <= q0_4_reg;
            r0_5_reg   <= r0_next;
            q0_6_reg   <= q0_5_reg;
            q2_6_reg   <= q2_prod[52:43];
            hq7_reg    <= hq_next;
            hq8_reg    <= hq7_reg;
            p8_reg     <= p_next;
            f9_reg     <= f_next;
            p9_reg     <= p8_reg;
            i10_reg    <= fd[FDW-1:22];
            r10_reg    <= fd[21:0];
            p10_reg    <= p9_reg;
            t0_11_reg  <= rom[i10_reg];
            t1_11_reg  <= rom[i10_reg + IW'(1)];
            r11_reg    <= r10_reg;
            p11_reg    <= p10_reg;
            step12_reg <= t1_11_reg - t0_11_reg;
            t0_12_reg  <= t0_11_reg;
            r12_reg    <= r11_reg;
            p12_reg    <= p11_reg;
            sp13_reg   <= sp_prod[50:22];
            t0_13_reg  <= t0_12_reg;
            p13_reg    <= p12_reg;
            lg14_reg   <= lg_next;
            mag15_reg  <= mag_next;
            neg15_reg  <= lg14_reg[33];
            pr16_reg   <= pr_next;
            neg16_reg  <= neg15_reg;
            l10_17_reg <= l10_next;
        end
    end

    assign out_valid    = v_reg[NS];
    assign out_meas.tc  = tc_reg[NS];
    assign out_meas.hum = hum_reg[NS];
    assign out_meas.l10 = l10_17_reg;

endmodule

[hw/rtl/humidity_temperature_dewpoint_unit.sv]
// Top level of the humidity / temperature / dew-point converter.
`timescale 1ns / 1ps

// Converts one raw humidity / temperature pair per clock into temperature,
// compensated relative humidity (0.1..100 %RH) and Magnus dew point, all in
// hundredths. The path is a fixed 69-stage pipeline: 17 stages for humidity
// compensation and the table-interpolated log10, an operand register, a
// 30-stage bit-per-stage divider for 7.5*t/(237.3+t), four combine stages,
// a 16-stage divider for the dew point and the output register. A new pair
// is taken every cycle unless the output is held. When the output is held by
// m_ready low, the whole pipe holds and s_ready drops in the same cycle.

module humidity_temperature_dewpoint_unit #(
    parameter int LOG_TABLE_DEPTH = htd_pkg::LOG_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_raw_humidity,
    input  logic [13:0]        s_raw_temperature,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_temperature_centi,
    output logic [13:0]        m_humidity_centi,
    output logic signed [14:0] m_dew_point_centi
);

    localparam int SW1 = $bits(htd_pkg::meas_t) + 1;
    localparam int SW2 = $bits(htd_pkg::dside_t);

    logic adv;

    logic           rl_valid;
    htd_pkg::meas_t rl_meas;

    logic           t1_v_reg;
    htd_pkg::meas_t t1_meas_reg;
    logic           t1_neg_reg;
    logic [19:0]    t1_mag75_reg;
    logic [18:0]    t1_den_reg;

    logic           d1_valid;
    logic [29:0]    d1_quo;
    logic [SW1-1:0] d1_side;
    htd_pkg::meas_t d1_meas;

    logic               t2_v_reg;
    logic signed [33:0] t2_l_reg;
    logic signed [14:0] t2_tc_reg;
    logic [13:0]        t2_hum_reg;

    logic               t3_v_reg;
    logic [30:0]        t3_lmag_reg;
    logic [31:0]        t3_den_reg;
    logic               t3_lneg_reg;
    logic               t3_bad_reg;
    logic signed [14:0] t3_tc_reg;
    logic [13:0]        t3_hum_reg;

    logic               t4_v_reg;
    logic [45:0]        t4_prod_reg;
    logic [31:0]        t4_den_reg;
    htd_pkg::dside_t    t4_side_reg;

    logic               t5_v_reg;
    logic [46:0]        t5_num_reg;
    logic [31:0]        t5_den_reg;
    htd_pkg::dside_t    t5_side_reg;

    logic               d2_valid;
    logic [15:0]        d2_quo;
    logic [SW2-1:0]     d2_side;
    htd_pkg::dside_t    d2_info;

    logic               m_valid_reg;
    logic signed [14:0] m_tc_reg;
    logic [13:0]        m_hum_reg;
    logic signed [14:0] m_dew_reg;

    logic [13:0]        abs_tc;
    logic [19:0]        mag75_next;
    logic [18:0]        den1_next;
    logic signed [33:0] a_mag;
    logic signed [33:0] a_val;
    logic signed [33:0] l_next;
    logic signed [33:0] den2;
    logic [30:0]        lmag_next;
    logic signed [16:0] dq;
    logic signed [14:0] dew_next;

    // Whole pipe moves unless the output holds an untaken result
    assign adv     = ~m_valid_reg | m_ready;
    assign s_ready = adv;

    htd_rhlog #(
        .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
    ) u_rhlog (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (s_valid),
        .raw_humidity    (s_raw_humidity),
        .raw_temperature (s_raw_temperature),
        .out_valid       (rl_valid),
        .out_meas        (rl_meas)
    );

    // Operands of 75*t*2^28 / (237300 + 10*t)
    always_comb begin
        abs_tc     = rl_meas.tc[14] ? 14'(-rl_meas.tc) : rl_meas.tc[13:0];
        mag75_next = 20'(abs_tc) * 20'd75;
        den1_next  = 19'(20'sd237300 + 20'(rl_meas.tc) * 20'sd10);
    end

    htd_div #(
        .QW(30),
        .DW(19),
        .SW(SW1)
    ) u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (t1_v_reg),
        .num_hi    ({1'b0, t1_mag75_reg[19:2]}),
        .num_lo    ({t1_mag75_reg[1:0], 10'd0, t1_den_reg[18:1]}),
        .den       (t1_den_reg),
        .side_in   ({t1_meas_reg, t1_neg_reg}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    assign d1_meas = htd_pkg::meas_t'(d1_side[SW1-1:1]);

    // Magnus exponent and dew-point operands
    always_comb begin
        a_mag     = $signed({4'd0, d1_quo});
        a_val     = d1_side[0] ? -a_mag : a_mag;
        l_next    = a_val + 34'(d1_meas.l10) - 34'sd536870912;
        den2      = 34'sd2013265920 - t2_l_reg;
        lmag_next = t2_l_reg[33] ? 31'(-t2_l_reg) : t2_l_reg[30:0];
    end

    htd_div #(
        .QW(16),
        .DW(32),
        .SW(SW2)
    ) u_div_dew (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (t5_v_reg),
        .num_hi    ({1'b0, t5_num_reg[46:16]}),
        .num_lo    (t5_num_reg[15:0]),
        .den       (t5_den_reg),
        .side_in   (t5_side_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    assign d2_info = htd_pkg::dside_t'(d2_side);

    // Sign, saturation and the non-positive divisor guard
    always_comb begin
        dq = d2_info.lneg ? -$signed({1'b0, d2_quo}) : $signed({1'b0, d2_quo});
        priority if (d2_info.bad) begin
            dew_next = 15'sd12400;
        end else if (dq < -17'sd9000) begin
            dew_next = -15'sd9000;
        end else if (dq > 17'sd12400) begin
            dew_next = 15'sd12400;
        end else begin
            dew_next = dq[14:0];
        end
    end

    // Valid bits of the glue stages and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_v_reg    <= 1'b0;
            t2_v_reg    <= 1'b0;
            t3_v_reg    <= 1'b0;
            t4_v_reg    <= 1'b0;
            t5_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            t1_v_reg    <= rl_valid;
            t2_v_reg    <= d1_valid;
            t3_v_reg    <= t2_v_reg;
            t4_v_reg    <= t3_v_reg;
            t5_v_reg    <= t4_v_reg;
            m_valid_reg <= d2_valid;
        end
    end

    // Glue stage data
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_meas_reg  <= rl_meas;
            t1_neg_reg   <= rl_meas.tc[14];
            t1_mag75_reg <= mag75_next;
            t1_den_reg   <= den1_next;

            t2_l_reg   <= l_next;
            t2_tc_reg  <= d1_meas.tc;
            t2_hum_reg <= d1_meas.hum;

            t3_lmag_reg <= lmag_next;
            t3_den_reg  <= den2[31:0];
            t3_lneg_reg <= t2_l_reg[33];
            t3_bad_reg  <= den2[33] | (den2 == 34'sd0);
            t3_tc_reg   <= t2_tc_reg;
            t3_hum_reg  <= t2_hum_reg;

            t4_prod_reg      <= 46'(t3_lmag_reg) * 46'd23730;
            t4_den_reg       <= t3_den_reg;
            t4_side_reg.tc   <= t3_tc_reg;
            t4_side_reg.hum  <= t3_hum_reg;
            t4_side_reg.lneg <= t3_lneg_reg;
            t4_side_reg.bad  <= t3_bad_reg;

            t5_num_reg  <= 47'(t4_prod_reg) + 47'(t4_den_reg[31:1]);
            t5_den_reg  <= t4_den_reg;
            t5_side_reg <= t4_side_reg;

            m_tc_reg  <= d2_info.tc;
            m_hum_reg <= d2_info.hum;
            m_dew_reg <= dew_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = m_tc_reg;
    assign m_humidity_centi    = m_hum_reg;
    assign m_dew_point_centi   = m_dew_reg;

    // Output ranges follow from the clamps and input widths in the pipe
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_humidity_centi >= 14'd10 && m_humidity_centi <= 14'd10000))
        else $error("humidity out of range");

    a_dew_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dew_point_centi >= -15'sd9000 && m_dew_point_centi <= 15'sd12400))
        else $error("dew point out of range");

    a_tc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_centi >= -15'sd4000 && m_temperature_centi <= 15'sd12383))
        else $error("temperature out of range");

endmodule
